### src/humidity_fan_controller_assert.svh
// Assertion macros for the fan controller.
// All checks are sampled on clk and switched off while rst_n is low.
`ifndef HUMIDITY_FAN_CONTROLLER_ASSERT_SVH
`define HUMIDITY_FAN_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define HFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hfc assertion failed");

// Next-cycle implication.
`define HFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hfc assertion failed");

`endif

### src/hfc_pkg.sv
package hfc_pkg;

  localparam int RH_W    = 10;
  localparam int TEMP_W  = 8;
  localparam int RUN_W   = 8;
  localparam int TICK_W  = 8;
  localparam int RFSH_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int HOLD_MIN_TICKS = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RH_START_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP_DEG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_SECONDS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC_M1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_SECONDS = 3'd4;

  // reset values
  localparam logic [RH_W-1:0]          RST_RH_START_CODE   = 10'd461;
  localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP_DEG    = 8'sd22;
  localparam logic [RUN_W-1:0]         RST_MIN_RUN_SECONDS = 8'd60;
  localparam logic [TICK_W-1:0]        RST_TICKS_PER_SEC_M1 = 8'd31;
  localparam logic [RFSH_W-1:0]        RST_REFRESH_SECONDS = 4'd5;

  typedef enum logic [1:0] {
    MODE_AUTO     = 2'd0,
    MODE_ON       = 2'd1,
    MODE_OFF      = 2'd2,
    MODE_SETTINGS = 2'd3
  } mode_t;

  typedef struct packed {
    logic [RH_W-1:0]          rh_start_code;
    logic signed [TEMP_W-1:0] min_temp_deg;
    logic [RUN_W-1:0]         min_run_seconds;
    logic [TICK_W-1:0]        ticks_per_second_m1;
    logic [RFSH_W-1:0]        refresh_seconds;
  } cfg_t;

endpackage

### src/hfc_cfg_regs.sv
module hfc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output hfc_pkg::cfg_t                  cfg
);
  import hfc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rh_start_code       <= RST_RH_START_CODE;
      cfg_r.min_temp_deg        <= RST_MIN_TEMP_DEG;
      cfg_r.min_run_seconds     <= RST_MIN_RUN_SECONDS;
      cfg_r.ticks_per_second_m1 <= RST_TICKS_PER_SEC_M1;
      cfg_r.refresh_seconds     <= RST_REFRESH_SECONDS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RH_START_CODE:    cfg_r.rh_start_code       <= cfg_data[RH_W-1:0];
        CFG_MIN_TEMP_DEG:     cfg_r.min_temp_deg        <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_MIN_RUN_SECONDS:  cfg_r.min_run_seconds     <= cfg_data[RUN_W-1:0];
        CFG_TICKS_PER_SEC_M1: cfg_r.ticks_per_second_m1 <= cfg_data[TICK_W-1:0];
        CFG_REFRESH_SECONDS:  cfg_r.refresh_seconds     <= cfg_data[RFSH_W-1:0];
        default: ; // unused indexes are dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/humidity_fan_controller.sv
// Humidity fan controller: one request per timer tick.
//
// Input channel (in_valid/in_ready): one request carries the button level, the
// 10-bit humidity ADC code, the signed temperature and the temperature-check
// enable. Output channel (out_valid/out_ready): one result per request with the
// fan drive, LED, mode, auto-rule view, display refresh pulse and reboot request.
// Configuration port: cfg_we writes cfg_data into register cfg_index at once;
// write only while no request is in flight.
//
// Result: a result appears in the cycle after its request is accepted. All of
// the per-tick work is a single combinational pass from the controller state
// registers into the state and result registers, so a request can be taken
// every cycle while no result stalls: throughput is one request per clock.
// Stall: the result register holds its value while out_ready is low; in_ready
// stays high as long as the result register is empty or being drained in the
// same cycle, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): fan off, auto mode, all counters cleared,
// configuration back to its defaults, result register empty.
module humidity_fan_controller #(
  parameter int LONG_HOLD_TICKS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_button_down,
  input  logic [hfc_pkg::RH_W-1:0]          in_humidity_code,
  input  logic signed [hfc_pkg::TEMP_W-1:0] in_temp_deg,
  input  logic                              in_temp_check_on,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_fan_running,
  output logic                              out_led_lit,
  output logic [1:0]                        out_mode,
  output logic                              out_auto_fan_view,
  output logic                              out_refresh_pulse,
  output logic                              out_reboot_request,
  // configuration
  input  logic                              cfg_we,
  input  logic [hfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hfc_pkg::*;

  // hold counter saturates at LONG_HOLD_TICKS, sized to hold it
  localparam int HOLD_W = $clog2(LONG_HOLD_TICKS + 1);
  localparam logic [HOLD_W-1:0] HOLD_LONG = HOLD_W'(LONG_HOLD_TICKS);
  localparam logic [HOLD_W-1:0] HOLD_MIN  = HOLD_W'(HOLD_MIN_TICKS);

  cfg_t cfg;

  hfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // controller state
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [RFSH_W-1:0] rfsh_r, rfsh_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              may_stop_r, may_stop_nxt;
  logic              fan_r, fan_nxt;
  logic              blink_r, blink_nxt;
  mode_t             mode_r, mode_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              view_r, view_nxt;

  // per-tick strobes
  logic refresh_c, reboot_c;

  // result register
  logic       out_valid_r;
  logic       fan_out_r, led_out_r, view_out_r, refresh_out_r, reboot_out_r;
  logic [1:0] mode_out_r;

  logic in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    logic  sec;
    logic  advance;
    logic  high;
    logic  blocked;
    mode_t mode_adv;

    tick_nxt     = tick_r;
    rfsh_nxt     = rfsh_r;
    run_nxt      = run_r;
    may_stop_nxt = may_stop_r;
    fan_nxt      = fan_r;
    blink_nxt    = blink_r;
    mode_nxt     = mode_r;
    hold_nxt     = hold_r;
    view_nxt     = view_r;
    refresh_c    = 1'b0;
    reboot_c     = 1'b0;
    advance      = 1'b0;
    mode_adv     = mode_r;

    // timekeeping: a second passes when the tick count reaches its limit
    sec = (tick_r >= cfg.ticks_per_second_m1);
    if (sec) begin
      tick_nxt = '0;
      if (rfsh_r == cfg.refresh_seconds) begin
        rfsh_nxt  = '0;
        refresh_c = 1'b1;
      end else begin
        rfsh_nxt = rfsh_r + 1'b1;
      end
      if (mode_r == MODE_AUTO && fan_r && !may_stop_r) begin
        if (run_r == cfg.min_run_seconds) begin
          may_stop_nxt = 1'b1;
          refresh_c    = 1'b1;  // minimum run just expired
        end
        run_nxt = run_r + 1'b1;
      end else begin
        run_nxt = '0;
      end
      blink_nxt = fan_r ? !blink_r : 1'b0;
    end else begin
      tick_nxt = tick_r + 1'b1;
    end

    // button: long hold asks for reboot, a normal press steps the mode
    if (in_button_down) begin
      if (hold_r < HOLD_LONG) begin
        hold_nxt = hold_r + 1'b1;
      end
    end else begin
      if (hold_r > HOLD_MIN) begin
        if (hold_r == HOLD_LONG) begin
          reboot_c = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      hold_nxt = '0;
    end

    if (advance) begin
      refresh_c = 1'b1;
      unique case (mode_r)
        MODE_AUTO: mode_adv = MODE_ON;
        MODE_ON:   mode_adv = MODE_OFF;
        MODE_OFF:  mode_adv = MODE_SETTINGS;
        default:   mode_adv = MODE_AUTO;
      endcase
      unique case (mode_adv)
        MODE_ON: begin
          fan_nxt  = 1'b1;
          tick_nxt = '0;
          mode_nxt = MODE_ON;
        end
        MODE_OFF: begin
          fan_nxt  = 1'b0;
          mode_nxt = MODE_OFF;
        end
        default: begin
          // settings drops straight back to auto
          tick_nxt = '0;
          mode_nxt = MODE_AUTO;
        end
      endcase
    end

    // auto rule; code 0 means sensor out of range
    high    = (in_humidity_code != '0) && (in_humidity_code > cfg.rh_start_code);
    blocked = in_temp_check_on && (in_temp_deg < cfg.min_temp_deg);
    if (mode_nxt == MODE_AUTO) begin
      if (high) begin
        if (!blocked) begin
          if (!fan_nxt) begin
            fan_nxt      = 1'b1;
            may_stop_nxt = 1'b0;
          end
          run_nxt  = '0;
          view_nxt = fan_nxt;
        end
      end else begin
        if (may_stop_nxt && fan_nxt) begin
          fan_nxt      = 1'b0;
          may_stop_nxt = 1'b0;
        end
        view_nxt = fan_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      rfsh_r     <= '0;
      run_r      <= '0;
      may_stop_r <= 1'b0;
      fan_r      <= 1'b0;
      blink_r    <= 1'b0;
      mode_r     <= MODE_AUTO;
      hold_r     <= '0;
      view_r     <= 1'b0;
    end else if (in_fire) begin
      tick_r     <= tick_nxt;
      rfsh_r     <= rfsh_nxt;
      run_r      <= run_nxt;
      may_stop_r <= may_stop_nxt;
      fan_r      <= fan_nxt;
      blink_r    <= blink_nxt;
      mode_r     <= mode_nxt;
      hold_r     <= hold_nxt;
      view_r     <= view_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fan_out_r     <= fan_nxt;
      led_out_r     <= blink_nxt;
      mode_out_r    <= mode_nxt;
      view_out_r    <= view_nxt;
      refresh_out_r <= refresh_c;
      reboot_out_r  <= reboot_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fan_running    = fan_out_r;
  assign out_led_lit        = led_out_r;
  assign out_mode           = mode_out_r;
  assign out_auto_fan_view  = view_out_r;
  assign out_refresh_pulse  = refresh_out_r;
  assign out_reboot_request = reboot_out_r;

  `include "humidity_fan_controller_assert.svh"

  // forced off never leaves the fan running
  `HFC_ASSERT_NOW(a_off_fan_stopped, mode_r == MODE_OFF, !fan_r)
  // a reboot release never steps the mode
  `HFC_ASSERT_NEXT(a_reboot_keeps_mode, in_fire && reboot_c, mode_r == $past(mode_r))
  // hold counter saturates
  `HFC_ASSERT_NOW(a_hold_saturates, 1'b1, hold_r <= HOLD_LONG)
  // input back-pressure only while a result is waiting
  `HFC_ASSERT_NOW(a_ready_when_empty, !in_ready, out_valid_r && !out_ready)

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hfc_pkg::*;

  // Hold length at which a release asks for a reboot instead of a mode step.
  localparam int HOLD_LONG = 128;
  // Idle cycles granted before a register write and at the end of the run.
  // The block answers in the cycle after a request, so a handful is plenty.
  localparam int SETTLE = 4;
  // Budget: every request at its worst idle gap and stall, plus register
  // writes, taken several times over.
  localparam int LIMIT = 400_000;
  localparam int PLAN_ROWS = 24;
  localparam int PHASES = 9;
  localparam int PHASE_TICKS = 65;

  // One timer tick as it travels on the request channel.
  typedef struct packed {
    logic             button_down;
    logic [RH_W-1:0]  humidity_code;
    logic [TEMP_W-1:0] temp_deg;
    logic             temp_check_on;
  } tick_req_t;

  // Everything the block reports after one tick.
  typedef struct packed {
    logic       fan_running;
    logic       led_lit;
    logic [1:0] mode;
    logic       auto_fan_view;
    logic       refresh_pulse;
    logic       reboot_request;
  } fan_status_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  // One line of the directed plan: either a register write or a tick
  // repeated reps times. Where known is set, the status is typed in.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    tick_req_t              req;
    int                     reps;
    bit                     known;
    fan_status_t            status;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_button_down = 1'b0;
  logic [RH_W-1:0]          in_humidity_code = '0;
  logic signed [TEMP_W-1:0] in_temp_deg = '0;
  logic                     in_temp_check_on = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_fan_running;
  logic       out_led_lit;
  logic [1:0] out_mode;
  logic       out_auto_fan_view;
  logic       out_refresh_pulse;
  logic       out_reboot_request;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  humidity_fan_controller #(
    .LONG_HOLD_TICKS(HOLD_LONG)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_button_down    (in_button_down),
    .in_humidity_code  (in_humidity_code),
    .in_temp_deg       (in_temp_deg),
    .in_temp_check_on  (in_temp_check_on),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fan_running   (out_fan_running),
    .out_led_lit       (out_led_lit),
    .out_mode          (out_mode),
    .out_auto_fan_view (out_auto_fan_view),
    .out_refresh_pulse (out_refresh_pulse),
    .out_reboot_request(out_reboot_request),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Controller shadow: configuration and per-tick state, updated once per
  // accepted request and once per register write.
  // ---------------------------------------------------------------------
  logic [RH_W-1:0]          cfg_rh;
  logic signed [TEMP_W-1:0] cfg_min_temp;
  logic [RUN_W-1:0]         cfg_min_run;
  logic [TICK_W-1:0]        cfg_tps;
  logic [RFSH_W-1:0]        cfg_rfsh;

  logic [TICK_W-1:0] tick_cnt;
  logic [RFSH_W-1:0] rfsh_cnt;
  logic [RUN_W-1:0]  run_secs;
  logic              may_stop;
  logic              fan_on;
  logic              led;
  mode_t             mode;
  logic [7:0]        hold;
  logic              view;

  fan_status_t fan_status_q[$];  // statuses owed by the block, oldest first
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;      // both sides run flat out while set
  plan_row_t   plan [PLAN_ROWS];

  function automatic void reset_fan_model();
    cfg_rh       = RST_RH_START_CODE;
    cfg_min_temp = RST_MIN_TEMP_DEG;
    cfg_min_run  = RST_MIN_RUN_SECONDS;
    cfg_tps      = RST_TICKS_PER_SEC_M1;
    cfg_rfsh     = RST_REFRESH_SECONDS;
    tick_cnt = '0;
    rfsh_cnt = '0;
    run_secs = '0;
    may_stop = 1'b0;
    fan_on   = 1'b0;
    led      = 1'b0;
    mode     = MODE_AUTO;
    hold     = '0;
    view     = 1'b0;
  endfunction

  // One tick: timekeeping, then the button, then the auto rule.
  function automatic fan_status_t step_fan_model(tick_req_t t);
    fan_status_t s;
    bit refresh, reboot, advance, high, decided;
    refresh = 1'b0;
    reboot  = 1'b0;
    advance = 1'b0;

    if (tick_cnt >= cfg_tps) begin
      tick_cnt = '0;
      if (rfsh_cnt == cfg_rfsh) begin
        rfsh_cnt = '0;
        refresh  = 1'b1;
      end else begin
        rfsh_cnt = rfsh_cnt + 1'b1;
      end
      // min-run timer only counts for an auto-started fan not yet released
      if (mode == MODE_AUTO && fan_on && !may_stop) begin
        if (run_secs == cfg_min_run) begin
          may_stop = 1'b1;
          refresh  = 1'b1;
        end
        run_secs = run_secs + 1'b1;
      end else begin
        run_secs = '0;
      end
      led = fan_on ? !led : 1'b0;
    end else begin
      tick_cnt = tick_cnt + 1'b1;
    end

    if (t.button_down) begin
      if (hold < HOLD_LONG) hold = hold + 1'b1;
    end else begin
      if (hold > HOLD_MIN_TICKS) begin
        if (hold == HOLD_LONG) reboot = 1'b1;
        else advance = 1'b1;
      end
      hold = '0;
    end

    if (advance) begin
      refresh = 1'b1;
      case (mode)
        MODE_AUTO: begin
          mode     = MODE_ON;
          fan_on   = 1'b1;
          tick_cnt = '0;
        end
        MODE_ON: begin
          mode   = MODE_OFF;
          fan_on = 1'b0;
        end
        default: begin
          // off steps to settings, which drops straight back to auto
          mode     = MODE_AUTO;
          tick_cnt = '0;
        end
      endcase
    end

    if (mode == MODE_AUTO) begin
      high    = (t.humidity_code != '0) && (t.humidity_code > cfg_rh);
      decided = 1'b1;
      if (high) begin
        if (t.temp_check_on && $signed(t.temp_deg) < cfg_min_temp) begin
          decided = 1'b0;  // too cold: rule sits this tick out
        end else begin
          if (!fan_on) begin
            fan_on   = 1'b1;
            may_stop = 1'b0;
          end
          run_secs = '0;
        end
      end else if (may_stop && fan_on) begin
        fan_on   = 1'b0;
        may_stop = 1'b0;
      end
      if (decided) view = fan_on;
    end

    s.fan_running    = fan_on;
    s.led_lit        = led;
    s.mode           = mode;
    s.auto_fan_view  = view;
    s.refresh_pulse  = refresh;
    s.reboot_request = reboot;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic tick_req_t make_req(bit btn, int hum, int temp, bit chk);
    tick_req_t r;
    r.button_down   = btn;
    r.humidity_code = hum[RH_W-1:0];
    r.temp_deg      = temp[TEMP_W-1:0];
    r.temp_check_on = chk;
    return r;
  endfunction

  function automatic plan_row_t tick_row(bit btn, int hum, int temp, bit chk, int reps);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.req  = make_req(btn, hum, temp, chk);
    r.reps = reps;
    return r;
  endfunction

  function automatic plan_row_t known_row(bit btn, int hum, int temp, bit chk,
                                          fan_status_t status);
    plan_row_t r;
    r        = tick_row(btn, hum, temp, chk, 1);
    r.known  = 1'b1;
    r.status = status;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val[CFG_DATA_W-1:0];
    return r;
  endfunction

  // Humidity either side of the start threshold, with some out-of-range
  // codes and fully random ones mixed in.
  function automatic int humidity_for(bit above);
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = $urandom_range(0, 1023);
      default: v = above ? int'(cfg_rh) + int'($urandom_range(1, 40))
                         : int'(cfg_rh) - int'($urandom_range(0, 40));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // Temperature hovering around the blocking limit.
  function automatic int temp_near();
    int v;
    if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 165)) - 40;
    else v = int'(cfg_min_temp) + int'($urandom_range(0, 6)) - 3;
    if (v < -40) v = -40;
    if (v > 125) v = 125;
    return v;
  endfunction

  // Present one request after a random pause and log what it should produce.
  task automatic send_tick(tick_req_t req, bit known, fan_status_t known_status);
    int gap;
    fan_status_t want;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_button_down   <= req.button_down;
    in_humidity_code <= req.humidity_code;
    in_temp_deg      <= req.temp_deg;
    in_temp_check_on <= req.temp_check_on;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = step_fan_model(req);
    fan_status_q.push_back(known ? known_status : want);
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding status come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fan_status_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_RH_START_CODE:    cfg_rh       = val[RH_W-1:0];
      CFG_MIN_TEMP_DEG:     cfg_min_temp = val[TEMP_W-1:0];
      CFG_MIN_RUN_SECONDS:  cfg_min_run  = val[RUN_W-1:0];
      CFG_TICKS_PER_SEC_M1: cfg_tps      = val[TICK_W-1:0];
      CFG_REFRESH_SECONDS:  cfg_rfsh     = val[RFSH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls, every accepted status checked against the
  // oldest one owed.
  // ---------------------------------------------------------------------
  initial begin : result_side
    int stall;
    fan_status_t got, want;
    bit bad;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {out_fan_running, out_led_lit, out_mode, out_auto_fan_view,
             out_refresh_pulse, out_reboot_request};
      if (fan_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("status with no request pending: %b", got);
      end else begin
        want = fan_status_q.pop_front();
        bad = (got.fan_running    !== want.fan_running)   ||
              (got.led_lit        !== want.led_lit)       ||
              (got.mode           !== want.mode)          ||
              (got.auto_fan_view  !== want.auto_fan_view) ||
              (got.refresh_pulse  !== want.refresh_pulse) ||
              (got.reboot_request !== want.reboot_request);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("status mismatch at %0t: fan/led/mode/view/refresh/reboot ", $realtime);
            $display("want %b/%b/%0d/%b/%b/%b got %b/%b/%0d/%b/%b/%b",
                     want.fan_running, want.led_lit, want.mode, want.auto_fan_view,
                     want.refresh_pulse, want.reboot_request,
                     got.fan_running, got.led_lit, got.mode, got.auto_fan_view,
                     got.refresh_pulse, got.reboot_request);
          end
        end
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Request side: directed plan, then random phases.
  // ---------------------------------------------------------------------
  initial begin : request_side
    int sent, hold_len, run_len, pick, mt;
    bit above;
    tick_req_t req;

    plan = '{
      // straight out of reset: nothing high, all quiet
      known_row(0, 0, 0, 0, fan_status_t'{1'b0, 1'b0, MODE_AUTO, 1'b0, 1'b0, 1'b0}),
      // full-scale humidity starts the fan; 125 deg clears the temp check
      known_row(0, 1023, 125, 1, fan_status_t'{1'b1, 1'b0, MODE_AUTO, 1'b1, 1'b0, 1'b0}),
      // every tick a second, short min run, refresh at the top of its range
      cfg_row(CFG_TICKS_PER_SEC_M1, 0),
      cfg_row(CFG_MIN_RUN_SECONDS, 2),
      cfg_row(CFG_REFRESH_SECONDS, 15),
      cfg_row(CFG_RH_START_CODE, 0),
      cfg_row(CFG_MIN_TEMP_DEG, 125),
      // out-of-range humidity: fan rides out its min run blinking, then stops
      tick_row(0, 0, 0, 0, 6),
      // code 1 is above threshold 0, but too cold with checking on
      tick_row(0, 1, -40, 1, 2),
      // right at the limit the start goes through
      tick_row(0, 1, 125, 1, 1),
      // two-tick press is too short to count
      tick_row(1, 1023, 0, 0, 2),
      tick_row(0, 1023, 0, 0, 1),
      // auto -> forced on
      tick_row(1, 0, 0, 0, 3),
      tick_row(0, 0, 0, 0, 4),
      // forced on -> forced off
      tick_row(1, 1023, 0, 0, 3),
      tick_row(0, 1023, 0, 0, 2),
      // forced off -> settings -> straight back to auto
      tick_row(1, 0, 0, 0, 3),
      tick_row(0, 0, 0, 0, 1),
      // long hold past saturation, release asks for a reboot
      tick_row(1, 512, 0, 0, HOLD_LONG + 12),
      tick_row(0, 512, 0, 0, 1),
      // threshold at full scale: no code is strictly above it
      cfg_row(CFG_RH_START_CODE, 1023),
      tick_row(0, 1023, -40, 0, 2),
      cfg_row(CFG_TICKS_PER_SEC_M1, 255),
      tick_row(0, 1023, -40, 1, 3)
    };

    reset_fan_model();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        repeat (plan[i].reps) send_tick(plan[i].req, plan[i].known, plan[i].status);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // first two phases pin every register low, then high (temperature to -40/125, min run to 254)
      case (ph)
        0: begin
          write_reg(CFG_RH_START_CODE, 10'd0);
          write_reg(CFG_MIN_TEMP_DEG, 10'(-40 & 255));
          write_reg(CFG_MIN_RUN_SECONDS, 10'd0);
          write_reg(CFG_TICKS_PER_SEC_M1, 10'd0);
          write_reg(CFG_REFRESH_SECONDS, 10'd0);
        end
        1: begin
          write_reg(CFG_RH_START_CODE, 10'd1023);
          write_reg(CFG_MIN_TEMP_DEG, 10'd125);
          write_reg(CFG_MIN_RUN_SECONDS, 10'd254);
          write_reg(CFG_TICKS_PER_SEC_M1, 10'd255);
          write_reg(CFG_REFRESH_SECONDS, 10'd15);
        end
        default: begin
          mt = int'($urandom_range(0, 165)) - 40;
          write_reg(CFG_RH_START_CODE, 10'($urandom_range(0, 1023)));
          write_reg(CFG_MIN_TEMP_DEG, 10'(mt & 255));
          write_reg(CFG_MIN_RUN_SECONDS, (ph == 7) ? 10'd255 : 10'($urandom_range(0, 8)));
          write_reg(CFG_TICKS_PER_SEC_M1,
                    (ph == 5) ? 10'($urandom_range(1, 255)) : 10'($urandom_range(0, 3)));
          write_reg(CFG_REFRESH_SECONDS, 10'($urandom_range(0, 15)));
        end
      endcase
      calm = (ph % 3 == 2);

      sent = 0;
      while (sent < PHASE_TICKS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4 || (sent == 0 && (ph == 2 || ph == 6))) begin
          // button press: hold, then release; two phases open with a long hold
          if (sent == 0 && (ph == 2 || ph == 6))
            hold_len = HOLD_LONG + $urandom_range(0, 6);
          else if ($urandom_range(0, 4) == 0)
            hold_len = $urandom_range(1, 2);
          else
            hold_len = $urandom_range(3, 10);
          for (int k = 0; k <= hold_len; k++) begin
            req = make_req(k < hold_len, humidity_for(1'($urandom_range(0, 1))),
                           temp_near(), 1'($urandom_range(0, 1)));
            send_tick(req, 1'b0, '0);
          end
          sent += hold_len + 1;
        end else if (pick < 9) begin
          // humidity run: steady high or low level, button released
          above   = 1'($urandom_range(0, 1));
          run_len = $urandom_range(1, 12);
          for (int k = 0; k < run_len; k++) begin
            req = make_req(1'b0, humidity_for(above), temp_near(),
                           1'($urandom_range(0, 1)));
            send_tick(req, 1'b0, '0);
          end
          sent += run_len;
        end else begin
          // noise tick
          req = make_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                         int'($urandom_range(0, 165)) - 40, 1'($urandom_range(0, 1)));
          send_tick(req, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && fan_status_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### humidity_fan_controller.f
+incdir+src
src/hfc_pkg.sv
src/hfc_cfg_regs.sv
src/humidity_fan_controller.sv
bench/tb_top.sv
